// File: sv/pse_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pse_pkg
// Types and constants shared by the postfix stack evaluator modules.
// ---------------------------------------------------------------------------
package pse_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_NUM,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_UNDER = 3'd1,
        STAT_OVER  = 3'd2,
        STAT_DIVZ  = 3'd3,
        STAT_ZNEG  = 3'd4,
        STAT_EMPTY = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_POW,
        S_FIN
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] digit;
        logic       last;
    } item_t;

endpackage
`default_nettype wire

// File: sv/pse_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pse_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: sv/pse_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pse_front
// Accept input items, classify each character and hand it to the queue.
// ---------------------------------------------------------------------------
module pse_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [7:0]     ch,
    input  wire logic           last,
    output logic                push,
    output pse_pkg::item_t      push_item,
    input  wire logic           full
);

    logic           valid_reg;
    logic           valid_next;
    pse_pkg::item_t item_reg;
    pse_pkg::item_t item_next;
    logic [7:0]     digit_full;

    assign in_stall   = valid_reg && full;
    assign push       = valid_reg && !full;
    assign push_item  = item_reg;
    assign digit_full = ch - pse_pkg::CH_ZERO;

    always_comb
    begin
        item_next       = item_reg;
        valid_next      = valid_reg && full;
        if (in_valid && !in_stall)
        begin
            valid_next      = 1'b1;
            item_next.last  = last;
            item_next.digit = digit_full[3:0];
            if (ch inside {[pse_pkg::CH_ZERO:pse_pkg::CH_NINE]})
            begin
                item_next.op = pse_pkg::OP_NUM;
            end
            else
            begin
                case (ch)
                    pse_pkg::CH_PLUS:  item_next.op = pse_pkg::OP_ADD;
                    pse_pkg::CH_MINUS: item_next.op = pse_pkg::OP_SUB;
                    pse_pkg::CH_STAR:  item_next.op = pse_pkg::OP_MUL;
                    pse_pkg::CH_SLASH: item_next.op = pse_pkg::OP_DIV;
                    pse_pkg::CH_CARET: item_next.op = pse_pkg::OP_POW;
                    default:           item_next.op = pse_pkg::OP_NOP;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule
`default_nettype wire

// File: sv/pse_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pse_queue
// Two-entry queue of classified items between front and back.
// ---------------------------------------------------------------------------
module pse_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  pse_pkg::item_t      push_item,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output pse_pkg::item_t      head_item
);

    pse_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// File: sv/pse_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pse_back
// Execute classified items on the operand stack and emit results.
// Top of stack lives in a register, deeper entries in RAM.
// ---------------------------------------------------------------------------
module pse_back #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  pse_pkg::item_t          head_item,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      value,
    output logic [2:0]              status
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int AW   = $clog2(STACK_DEPTH);

    pse_pkg::state_t  state_reg, state_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    logic [31:0]      tos_reg, tos_next;
    pse_pkg::status_t err_reg, err_next;
    pse_pkg::op_t     op_reg, op_next;
    logic             last_reg, last_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      value_reg, value_next;
    pse_pkg::status_t status_reg, status_next;

    logic [31:0]      a_reg, a_next;
    logic [31:0]      d_reg, d_next;
    logic [31:0]      rem_reg, rem_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [31:0]      acc_reg, acc_next;
    logic [31:0]      base_reg, base_next;
    logic [30:0]      ex_reg, ex_next;
    logic             phase_reg, phase_next;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [31:0]      rdata;
    logic [SP_W-1:0]  sp_m1;
    logic [SP_W-1:0]  sp_m2;
    logic [32:0]      shifted;
    logic             ge;
    logic [31:0]      qbits;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      product;
    logic [31:0]      l_mag;
    logic [31:0]      r_mag;

    pse_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (tos_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sp_m1     = sp_reg - SP_W'(1);
    assign sp_m2     = sp_reg - SP_W'(2);
    assign waddr     = sp_m1[AW-1:0];
    assign raddr     = sp_m2[AW-1:0];
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign shifted   = {rem_reg, a_reg[31]};
    assign ge        = (shifted >= {1'b0, d_reg});
    assign qbits     = {a_reg[30:0], ge};
    assign l_mag     = rdata[31] ? (32'd0 - rdata) : rdata;
    assign r_mag     = tos_reg[31] ? (32'd0 - tos_reg) : tos_reg;
    assign mul_a     = (state_reg == pse_pkg::S_POW && !phase_reg) ? acc_reg
                     : (state_reg == pse_pkg::S_POW) ? base_reg : rdata;
    assign mul_b     = (state_reg == pse_pkg::S_POW) ? base_reg : tos_reg;
    assign product   = mul_a * mul_b;

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        tos_next       = tos_reg;
        err_next       = err_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        status_next    = status_reg;
        a_next         = a_reg;
        d_next         = d_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        ex_next        = ex_reg;
        phase_next     = phase_reg;
        pop            = 1'b0;
        we             = 1'b0;

        case (state_reg)
            pse_pkg::S_IDLE:
            begin
                if (head_valid && !(head_item.last && out_valid_reg))
                begin
                    pop        = 1'b1;
                    last_next  = head_item.last;
                    op_next    = head_item.op;
                    state_next = head_item.last ? pse_pkg::S_FIN : pse_pkg::S_IDLE;
                    case (head_item.op)
                        pse_pkg::OP_NOP:
                        begin
                        end
                        pse_pkg::OP_NUM:
                        begin
                            if (sp_reg == SP_W'(STACK_DEPTH))
                            begin
                                if (err_reg == pse_pkg::STAT_OK)
                                begin
                                    err_next = pse_pkg::STAT_OVER;
                                end
                            end
                            else
                            begin
                                we       = (sp_reg != '0);
                                tos_next = {28'd0, head_item.digit};
                                sp_next  = sp_reg + SP_W'(1);
                            end
                        end
                        default:
                        begin
                            if (sp_reg < SP_W'(2))
                            begin
                                if (err_reg == pse_pkg::STAT_OK)
                                begin
                                    err_next = pse_pkg::STAT_UNDER;
                                end
                            end
                            else
                            begin
                                state_next = pse_pkg::S_READ;
                            end
                        end
                    endcase
                end
            end

            pse_pkg::S_READ:
            begin
                state_next = last_reg ? pse_pkg::S_FIN : pse_pkg::S_IDLE;
                sp_next    = sp_m1;
                case (op_reg)
                    pse_pkg::OP_ADD: tos_next = rdata + tos_reg;
                    pse_pkg::OP_SUB: tos_next = rdata - tos_reg;
                    pse_pkg::OP_MUL: tos_next = product[31:0];
                    pse_pkg::OP_DIV:
                    begin
                        if (tos_reg == 32'd0)
                        begin
                            tos_next = 32'd0;
                            if (err_reg == pse_pkg::STAT_OK)
                            begin
                                err_next = pse_pkg::STAT_DIVZ;
                            end
                        end
                        else
                        begin
                            sp_next    = sp_reg;
                            state_next = pse_pkg::S_DIV;
                            a_next     = l_mag;
                            d_next     = r_mag;
                            rem_next   = 32'd0;
                            cnt_next   = 5'd0;
                            neg_next   = rdata[31] ^ tos_reg[31];
                        end
                    end
                    default:
                    begin
                        if (tos_reg[31])
                        begin
                            if (rdata == 32'd1)
                            begin
                                tos_next = 32'd1;
                            end
                            else if (rdata == 32'hFFFF_FFFF)
                            begin
                                tos_next = tos_reg[0] ? 32'hFFFF_FFFF : 32'd1;
                            end
                            else
                            begin
                                tos_next = 32'd0;
                                if (rdata == 32'd0 && err_reg == pse_pkg::STAT_OK)
                                begin
                                    err_next = pse_pkg::STAT_ZNEG;
                                end
                            end
                        end
                        else
                        begin
                            sp_next    = sp_reg;
                            state_next = pse_pkg::S_POW;
                            acc_next   = 32'd1;
                            base_next  = rdata;
                            ex_next    = tos_reg[30:0];
                            phase_next = 1'b0;
                        end
                    end
                endcase
            end

            pse_pkg::S_DIV:
            begin
                rem_next = ge ? 32'(shifted - {1'b0, d_reg}) : shifted[31:0];
                a_next   = qbits;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    tos_next   = neg_reg ? (32'd0 - qbits) : qbits;
                    sp_next    = sp_m1;
                    state_next = last_reg ? pse_pkg::S_FIN : pse_pkg::S_IDLE;
                end
            end

            pse_pkg::S_POW:
            begin
                if (ex_reg == 31'd0)
                begin
                    tos_next   = acc_reg;
                    sp_next    = sp_m1;
                    state_next = last_reg ? pse_pkg::S_FIN : pse_pkg::S_IDLE;
                end
                else if (!phase_reg)
                begin
                    if (ex_reg[0])
                    begin
                        acc_next = product[31:0];
                    end
                    phase_next = 1'b1;
                end
                else
                begin
                    base_next  = product[31:0];
                    ex_next    = ex_reg >> 1;
                    phase_next = 1'b0;
                end
            end

            pse_pkg::S_FIN:
            begin
                out_valid_next = 1'b1;
                value_next     = (sp_reg != '0) ? tos_reg : 32'd0;
                if (err_reg != pse_pkg::STAT_OK)
                begin
                    status_next = err_reg;
                end
                else if (sp_reg == '0)
                begin
                    status_next = pse_pkg::STAT_EMPTY;
                end
                else
                begin
                    status_next = pse_pkg::STAT_OK;
                end
                sp_next    = '0;
                err_next   = pse_pkg::STAT_OK;
                state_next = pse_pkg::S_IDLE;
            end

            default:
            begin
                state_next = pse_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pse_pkg::S_IDLE;
            sp_reg        <= '0;
            err_reg       <= pse_pkg::STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg    <= tos_next;
        op_reg     <= op_next;
        last_reg   <= last_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        a_reg      <= a_next;
        d_reg      <= d_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        base_reg   <= base_next;
        ex_reg     <= ex_next;
        phase_reg  <= phase_next;
    end

endmodule
`default_nettype wire

// File: sv/postfix_stack_evaluator_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// postfix_stack_evaluator_top
// Postfix expression evaluator on a bounded 32-bit operand stack.
// ---------------------------------------------------------------------------
// One character arrives per item; the item marked last yields value and
// status. The front stage registers and classifies each item into a
// two-entry queue, so input is taken while the back end works. The back end
// takes one queued item at a time: a digit or an ignored character is
// handled in the idle state; an operator with two operands then passes a
// read state, as the stack RAM has a registered read port; / by a nonzero
// divisor then runs the restoring divider, one quotient bit per cycle; ^
// with a non-negative exponent loops over its bits up to the highest set
// bit on one shared multiplier; the last item passes a final state that
// loads the output register. The stack keeps its top entry in a register.
module postfix_stack_evaluator_top #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         ch,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      value,
    output logic [2:0]              status
);

    logic           push;
    pse_pkg::item_t push_item;
    logic           full;
    logic           pop;
    logic           head_valid;
    pse_pkg::item_t head_item;

    pse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .last      (last),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    pse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    pse_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .status     (status)
    );

endmodule
`default_nettype wire

// File: sv/pse_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pse_checker
// Port-level checks for the postfix stack evaluator.
// ---------------------------------------------------------------------------
module pse_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic signed [31:0] value,
    input  wire logic [2:0]         status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
        else $error("result item changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 3'd6 && status != 3'd7)
        else $error("status code out of range");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pse_pkg::STAT_EMPTY |-> value == 32'sd0)
        else $error("empty stack result with nonzero value");

endmodule

bind postfix_stack_evaluator_top pse_checker u_pse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
);
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the postfix stack evaluator.
// ---------------------------------------------------------------------------
// Feeds expression characters through the valid/stall input channel: a
// table of directed expressions covering limits and every error, then
// random well-formed expressions mixed with noise and broken sequences.
// A local evaluator predicts value and status for every last character;
// results are compared in order. Both sides insert random idle gaps.
module tb;

    localparam int     DEPTH       = pse_pkg::STACK_DEPTH;
    localparam int     N_ITEMS     = 1850;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [7:0]       c;
        logic             lst;
        logic             has_exp;
        logic [31:0]      exp_value;
        pse_pkg::status_t exp_status;
    } row_t;

    typedef struct {
        logic [31:0]      v;
        pse_pkg::status_t st;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  ch;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic signed [31:0] value;
    logic [2:0]  status;

    logic [31:0]      eval_stack [DEPTH];
    int               eval_sp;
    pse_pkg::status_t eval_err;
    answer_t          answers_due[$];
    row_t             directed[$];
    logic [7:0]       pending_c[$];
    logic             pending_l[$];
    bit               failed;
    longint           cycles;

    postfix_stack_evaluator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .status    (status)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void flag_error(pse_pkg::status_t code);
        if (eval_err == pse_pkg::STAT_OK)
            eval_err = code;
    endfunction

    function automatic logic [31:0] abs32(logic [31:0] x);
        return x[31] ? 32'd0 - x : x;
    endfunction

    function automatic logic [31:0] raise(logic [31:0] b, logic [31:0] e);
        logic [31:0] acc;
        acc = 32'd1;
        if (e[31])
        begin
            if (b == 32'd1)
                return 32'd1;
            if (b == 32'hFFFF_FFFF)
                return e[0] ? 32'hFFFF_FFFF : 32'd1;
            if (b == 32'd0)
                flag_error(pse_pkg::STAT_ZNEG);
            return 32'd0;
        end
        while (e != 32'd0)
        begin
            if (e[0])
                acc = acc * b;
            b = b * b;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic void evaluate_char(logic [7:0] c, logic lst);
        logic [31:0] l, r, q, res;
        answer_t a;
        if (c >= pse_pkg::CH_ZERO && c <= pse_pkg::CH_NINE)
        begin
            if (eval_sp >= DEPTH)
                flag_error(pse_pkg::STAT_OVER);
            else
            begin
                eval_stack[eval_sp] = {24'd0, c - pse_pkg::CH_ZERO};
                eval_sp++;
            end
        end
        else if (c == pse_pkg::CH_PLUS || c == pse_pkg::CH_MINUS
                 || c == pse_pkg::CH_STAR || c == pse_pkg::CH_SLASH
                 || c == pse_pkg::CH_CARET)
        begin
            if (eval_sp < 2)
                flag_error(pse_pkg::STAT_UNDER);
            else
            begin
                r = eval_stack[eval_sp - 1];
                l = eval_stack[eval_sp - 2];
                if (c == pse_pkg::CH_PLUS)
                    res = l + r;
                else if (c == pse_pkg::CH_MINUS)
                    res = l - r;
                else if (c == pse_pkg::CH_STAR)
                    res = l * r;
                else if (c == pse_pkg::CH_SLASH)
                begin
                    if (r == 32'd0)
                    begin
                        flag_error(pse_pkg::STAT_DIVZ);
                        res = 32'd0;
                    end
                    else
                    begin
                        q = abs32(l) / abs32(r);
                        res = (l[31] ^ r[31]) ? 32'd0 - q : q;
                    end
                end
                else
                    res = raise(l, r);
                eval_sp--;
                eval_stack[eval_sp - 1] = res;
            end
        end
        if (!lst)
            return;
        a.v = (eval_sp > 0) ? eval_stack[eval_sp - 1] : 32'd0;
        if (eval_err != pse_pkg::STAT_OK)
            a.st = eval_err;
        else if (eval_sp == 0)
            a.st = pse_pkg::STAT_EMPTY;
        else
            a.st = pse_pkg::STAT_OK;
        answers_due.push_back(a);
        eval_sp = 0;
        eval_err = pse_pkg::STAT_OK;
    endfunction

    function automatic void add_row(logic [7:0] c, logic lst, logic he = 1'b0,
                                    logic [31:0] ev = 32'd0,
                                    pse_pkg::status_t es = pse_pkg::STAT_OK);
        row_t r;
        r.c = c;
        r.lst = lst;
        r.has_exp = he;
        r.exp_value = ev;
        r.exp_status = es;
        directed.push_back(r);
    endfunction

    function automatic logic [7:0] rand_digit();
        return pse_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 4))
            0: return pse_pkg::CH_PLUS;
            1: return pse_pkg::CH_MINUS;
            2: return pse_pkg::CH_STAR;
            3: return pse_pkg::CH_SLASH;
            default: return pse_pkg::CH_CARET;
        endcase
    endfunction

    // Build one random expression into the pending queues.
    function automatic void make_expression();
        int depth, n, k;
        logic [7:0] c;
        n = $urandom_range(1, 12);
        depth = 0;
        k = $urandom_range(0, 9);
        for (int i = 0; i < n; i++)
        begin
            if (k == 0)
                c = 8'($urandom);
            else if (k == 1 && $urandom_range(0, 3) == 0)
                c = rand_op();
            else if (depth >= 2 && (k == 2 || $urandom_range(0, 1) == 0))
            begin
                c = rand_op();
                depth--;
            end
            else
            begin
                c = rand_digit();
                depth++;
            end
            if (k == 3 && $urandom_range(0, 4) == 0)
                c = 8'($urandom);
            pending_c.push_back(c);
            pending_l.push_back(1'b0);
        end
        if (k >= 4)
            while (depth >= 2)
            begin
                pending_c.push_back(rand_op());
                pending_l.push_back(1'b0);
                depth--;
            end
        if (k == 9)
            for (int i = 0; i < DEPTH + 2; i++)
            begin
                pending_c.push_back(rand_digit());
                pending_l.push_back(1'b0);
            end
        pending_l[pending_l.size() - 1] = 1'b1;
    endfunction

    // Drive one item; a typed expectation replaces the predicted result.
    task automatic send(logic [7:0] c, logic lst, logic he, logic [31:0] ev,
                        pse_pkg::status_t es);
        int gap;
        answer_t a;
        gap = $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        last <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        evaluate_char(c, lst);
        if (he && lst)
        begin
            a = answers_due[answers_due.size() - 1];
            if (a.v !== ev)
            begin
                $error("value expected %0d actual %0d", $signed(ev), $signed(a.v));
                failed = 1'b1;
            end
            if (a.st !== es)
            begin
                $error("status expected %0d actual %0d", es, a.st);
                failed = 1'b1;
            end
            a.v = ev;
            a.st = es;
            answers_due[answers_due.size() - 1] = a;
        end
    endtask

    // Result side: compare against the oldest prediction.
    always @(posedge clk)
    begin
        answer_t a;
        if (rst_n && out_valid && !out_stall)
        begin
            if (answers_due.size() == 0)
            begin
                $error("unexpected result value=%0d status=%0d", value, status);
                failed = 1'b1;
            end
            else
            begin
                a = answers_due.pop_front();
                if (value !== a.v)
                begin
                    $error("value expected %0d actual %0d", $signed(a.v), value);
                    failed = 1'b1;
                end
                if (status !== a.st)
                begin
                    $error("status expected %0d actual %0d", a.st, status);
                    failed = 1'b1;
                end
            end
        end
    end

    // Result side: stall a random number of cycles before each item.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            n = $urandom_range(0, 17);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int         sent;
        logic [7:0] c;
        logic       l;
        rst_n = 1'b0;
        in_valid = 1'b0;
        ch = 8'd0;
        last = 1'b0;
        failed = 1'b0;
        cycles = 0;
        eval_sp = 0;
        eval_err = pse_pkg::STAT_OK;
        sent = 0;

        add_row(8'h00, 1'b1, 1'b1, 32'd0, pse_pkg::STAT_EMPTY);
        add_row(pse_pkg::CH_PLUS, 1'b1, 1'b1, 32'd0, pse_pkg::STAT_UNDER);
        add_row(pse_pkg::CH_NINE, 1'b1, 1'b1, 32'd9, pse_pkg::STAT_OK);
        add_row(pse_pkg::CH_ZERO, 1'b0);
        add_row(pse_pkg::CH_ZERO, 1'b0);
        add_row(pse_pkg::CH_SLASH, 1'b1, 1'b1, 32'd0, pse_pkg::STAT_DIVZ);
        add_row(pse_pkg::CH_ZERO, 1'b0);
        add_row(pse_pkg::CH_ZERO, 1'b0);
        add_row(pse_pkg::CH_NINE, 1'b0);
        add_row(pse_pkg::CH_MINUS, 1'b0);
        add_row(pse_pkg::CH_CARET, 1'b1, 1'b1, 32'd0, pse_pkg::STAT_ZNEG);
        add_row(8'hFF, 1'b0);
        add_row(pse_pkg::CH_NINE, 1'b0);
        add_row(pse_pkg::CH_NINE, 1'b0);
        add_row(pse_pkg::CH_STAR, 1'b0);
        add_row(pse_pkg::CH_NINE, 1'b0);
        add_row(pse_pkg::CH_CARET, 1'b1);
        // most negative value divided by -1
        add_row(8'h32, 1'b0);
        add_row(pse_pkg::CH_NINE, 1'b0);
        add_row(8'h33, 1'b0);
        add_row(pse_pkg::CH_STAR, 1'b0);
        add_row(8'h34, 1'b0);
        add_row(pse_pkg::CH_PLUS, 1'b0);
        add_row(pse_pkg::CH_CARET, 1'b0);
        add_row(pse_pkg::CH_ZERO, 1'b0);
        add_row(8'h31, 1'b0);
        add_row(pse_pkg::CH_MINUS, 1'b0);
        add_row(pse_pkg::CH_SLASH, 1'b1, 1'b1, 32'h8000_0000, pse_pkg::STAT_OK);
        // full stack, then one push too many
        for (int i = 0; i < DEPTH; i++)
            add_row(8'h31, 1'b0);
        add_row(8'h37, 1'b1, 1'b1, 32'd1, pse_pkg::STAT_OVER);
        // minus one to a negative odd power
        add_row(pse_pkg::CH_ZERO, 1'b0);
        add_row(8'h31, 1'b0);
        add_row(pse_pkg::CH_MINUS, 1'b0);
        add_row(pse_pkg::CH_ZERO, 1'b0);
        add_row(8'h33, 1'b0);
        add_row(pse_pkg::CH_MINUS, 1'b0);
        add_row(pse_pkg::CH_CARET, 1'b1, 1'b1, 32'hFFFF_FFFF, pse_pkg::STAT_OK);
        // one to a negative power
        add_row(8'h31, 1'b0);
        add_row(pse_pkg::CH_ZERO, 1'b0);
        add_row(8'h32, 1'b0);
        add_row(pse_pkg::CH_MINUS, 1'b0);
        add_row(pse_pkg::CH_CARET, 1'b1, 1'b1, 32'd1, pse_pkg::STAT_OK);
        // other base to a negative power
        add_row(8'h32, 1'b0);
        add_row(pse_pkg::CH_ZERO, 1'b0);
        add_row(8'h31, 1'b0);
        add_row(pse_pkg::CH_MINUS, 1'b0);
        add_row(pse_pkg::CH_CARET, 1'b1, 1'b1, 32'd0, pse_pkg::STAT_OK);
        // keep the first error only
        add_row(pse_pkg::CH_PLUS, 1'b0);
        add_row(pse_pkg::CH_ZERO, 1'b0);
        add_row(pse_pkg::CH_ZERO, 1'b0);
        add_row(pse_pkg::CH_SLASH, 1'b1, 1'b1, 32'd0, pse_pkg::STAT_UNDER);
        add_row(8'h35, 1'b0);
        add_row(pse_pkg::CH_STAR, 1'b1, 1'b1, 32'd5, pse_pkg::STAT_UNDER);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send(directed[i].c, directed[i].lst, directed[i].has_exp,
                 directed[i].exp_value, directed[i].exp_status);
            sent++;
        end

        while (sent < N_ITEMS)
        begin
            make_expression();
            while (pending_c.size() > 0)
            begin
                c = pending_c.pop_front();
                l = pending_l.pop_front();
                send(c, l, 1'b0, 32'd0, pse_pkg::STAT_OK);
                sent++;
            end
        end
        in_valid <= 1'b0;

        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (failed)
            $display("CHECK FAILED");
        else
            $display("CHECK OK");
        $finish;
    end
endmodule

// File: filelist.f
sv/pse_pkg.sv
sv/pse_ram.sv
sv/pse_front.sv
sv/pse_queue.sv
sv/pse_back.sv
sv/postfix_stack_evaluator_top.sv
sv/pse_checker.sv
tb/tb.sv
